[hw/rtl/debounced_button_panel_long_press_core_defines.svh]
// ----------------------------------------------------------------------------
// Button panel assertion macros
// Shared concurrent assertion helpers for the button panel core.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_PANEL_LONG_PRESS_CORE_DEFINES_SVH
`define DEBOUNCED_BUTTON_PANEL_LONG_PRESS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBPL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DBPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[hw/rtl/dbpl_pkg.sv]
// ----------------------------------------------------------------------------
// Button panel package
// Types, codes and reset constants shared by the button panel modules.
// ----------------------------------------------------------------------------
package dbpl_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int MODE_COUNT_DEF = 4;
    localparam int NUM_BUTTONS    = 3;

    localparam int BTN_BOOT  = 0;
    localparam int BTN_PLUS  = 1;
    localparam int BTN_MINUS = 2;

    localparam int TICK_W      = 32;
    localparam int THRESH_W    = 16;
    localparam int SET_W       = 8;
    localparam int MODE_OUT_W  = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [THRESH_W-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    typedef enum logic [1:0] {
        OP_SCAN       = 2'd0,
        OP_SET_MODE   = 2'd1,
        OP_ARM_IGNORE = 2'd2,
        OP_TAKE_ACT   = 2'd3
    } op_t;

    // Control from the merge stage to each debounce lane.
    typedef struct packed {
        logic step;
        logic first;
    } lane_ctrl_t;

    // Status from a debounce lane to the merge stage.
    typedef struct packed {
        logic changed;
        logic pressed_next;
        logic pressed_now;
    } lane_stat_t;

    typedef struct packed {
        logic [MODE_OUT_W-1:0] mode_value;
        logic                  led_boot;
        logic                  led_plus;
        logic                  led_minus;
        logic                  short_press;
        logic                  long_press;
        logic                  activity;
    } res_t;

endpackage

[hw/rtl/dbpl_if.sv]
// ----------------------------------------------------------------------------
// Button panel channels
// Valid/ready channels for scan items, results and register writes.
// ----------------------------------------------------------------------------
interface dbpl_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic [dbpl_pkg::TICK_W-1:0]       now_tick;
    logic                              boot_level;
    logic                              plus_level;
    logic                              minus_level;
    logic [dbpl_pkg::SET_W-1:0]        set_value;

    modport source (output valid, op, now_tick, boot_level, plus_level, minus_level,
                    set_value, input ready);
    modport sink   (input valid, op, now_tick, boot_level, plus_level, minus_level,
                    set_value, output ready);
endinterface

interface dbpl_out_if;
    logic                              valid;
    logic                              ready;
    logic [dbpl_pkg::MODE_OUT_W-1:0]   mode_value;
    logic                              led_boot;
    logic                              led_plus;
    logic                              led_minus;
    logic                              short_press;
    logic                              long_press;
    logic                              activity;

    modport source (output valid, mode_value, led_boot, led_plus, led_minus,
                    short_press, long_press, activity, input ready);
    modport sink   (input valid, mode_value, led_boot, led_plus, led_minus,
                    short_press, long_press, activity, output ready);
endinterface

interface dbpl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dbpl_pkg::CFG_IDX_W-1:0]    index;
    logic [dbpl_pkg::THRESH_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dbpl_lane.sv]
// ----------------------------------------------------------------------------
// Button panel debounce lane
// Tracks the raw and stable level of one button and reports a stable change.
// ----------------------------------------------------------------------------
module dbpl_lane #(
    parameter int TIME_BITS = dbpl_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dbpl_pkg::lane_ctrl_t            ctrl,
    input  logic                            pressed,
    input  logic [TIME_BITS-1:0]            now,
    input  logic [dbpl_pkg::THRESH_W-1:0]   debounce_ticks,
    output dbpl_pkg::lane_stat_t            stat
);

    logic                 raw_reg;
    logic                 stable_reg;
    logic [TIME_BITS-1:0] change_reg;

    logic                 restart;
    logic [TIME_BITS-1:0] change_next;
    logic [TIME_BITS-1:0] delta;
    logic                 held;
    logic                 changed;
    logic                 stable_next;

    always_comb
    begin
        restart     = (pressed != raw_reg);
        change_next = (restart || ctrl.first) ? now : change_reg;
        delta       = now - change_next;
        held        = (delta >= TIME_BITS'(debounce_ticks));
        changed     = !ctrl.first && (pressed != stable_reg) && held;
        stable_next = (ctrl.first || changed) ? pressed : stable_reg;

        stat.changed      = changed;
        stat.pressed_next = stable_next;
        stat.pressed_now  = stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= 1'b0;
            stable_reg <= 1'b0;
            change_reg <= '0;
        end
        else if (ctrl.step)
        begin
            raw_reg    <= pressed;
            stable_reg <= stable_next;
            change_reg <= change_next;
        end
    end

endmodule

[hw/rtl/dbpl_merge.sv]
// ----------------------------------------------------------------------------
// Button panel merge stage
// Combines lane results into boot press events, mode steps and activity,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module dbpl_merge #(
    parameter int MODE_COUNT = dbpl_pkg::MODE_COUNT_DEF,
    parameter int TIME_BITS  = dbpl_pkg::TIME_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    dbpl_in_if.sink                                      sample,
    dbpl_out_if.source                                   result,
    input  logic [TIME_BITS-1:0]                         now,
    input  logic [dbpl_pkg::THRESH_W-1:0]                long_press_ticks,
    input  dbpl_pkg::lane_stat_t [dbpl_pkg::NUM_BUTTONS-1:0] stats,
    output dbpl_pkg::lane_ctrl_t                         lane_ctrl
);

    localparam int MODE_W = $clog2(MODE_COUNT);
    localparam logic [MODE_W-1:0] MODE_MAX = MODE_W'(MODE_COUNT - 1);

    logic                 started_reg,     started_next;
    logic [TIME_BITS-1:0] press_start_reg, press_start_next;
    logic                 long_fired_reg,  long_fired_next;
    logic                 ignore_reg,      ignore_next;
    logic                 activity_reg,    activity_next;
    logic [MODE_W-1:0]    mode_reg,        mode_next;
    logic                 out_valid_reg,   out_valid_next;
    dbpl_pkg::res_t       res_reg,         res_next;

    dbpl_pkg::op_t        op;
    logic                 accept;
    logic                 boot_press;
    logic                 boot_release;
    logic                 lf_eff;
    logic [TIME_BITS-1:0] ps_eff;
    logic [TIME_BITS-1:0] held_time;
    logic                 lp;
    logic                 sp;
    logic [MODE_W-1:0]    mode_up;
    logic [MODE_W-1:0]    mode_dn;
    logic                 act_out;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign op           = dbpl_pkg::op_t'(sample.op);

    assign lane_ctrl.step  = accept && (op == dbpl_pkg::OP_SCAN);
    assign lane_ctrl.first = !started_reg;

    always_comb
    begin
        started_next     = started_reg;
        press_start_next = press_start_reg;
        long_fired_next  = long_fired_reg;
        ignore_next      = ignore_reg;
        activity_next    = activity_reg;
        mode_next        = mode_reg;
        lp               = 1'b0;
        sp               = 1'b0;
        act_out          = activity_reg;

        boot_press   = stats[dbpl_pkg::BTN_BOOT].changed
                       && stats[dbpl_pkg::BTN_BOOT].pressed_next;
        boot_release = stats[dbpl_pkg::BTN_BOOT].changed
                       && !stats[dbpl_pkg::BTN_BOOT].pressed_next;

        // A newly stable boot press restarts the hold timer before the check.
        ps_eff    = boot_press ? now : press_start_reg;
        lf_eff    = boot_press ? 1'b0 : long_fired_reg;
        held_time = now - ps_eff;

        mode_up = (mode_reg == MODE_MAX) ? '0 : mode_reg + MODE_W'(1);
        mode_dn = mode_reg;

        case (op)
            dbpl_pkg::OP_SCAN:
            begin
                if (!started_reg)
                begin
                    started_next     = 1'b1;
                    press_start_next = now;
                    long_fired_next  = 1'b0;
                end
                else
                begin
                    press_start_next = ps_eff;
                    long_fired_next  = lf_eff;
                    if ((stats[dbpl_pkg::BTN_BOOT].changed
                         && stats[dbpl_pkg::BTN_BOOT].pressed_next)
                        || (stats[dbpl_pkg::BTN_PLUS].changed
                            && stats[dbpl_pkg::BTN_PLUS].pressed_next)
                        || (stats[dbpl_pkg::BTN_MINUS].changed
                            && stats[dbpl_pkg::BTN_MINUS].pressed_next))
                    begin
                        activity_next = 1'b1;
                    end
                    if (ignore_reg)
                    begin
                        if (boot_release)
                        begin
                            ignore_next = 1'b0;
                        end
                    end
                    else
                    begin
                        lp = stats[dbpl_pkg::BTN_BOOT].pressed_next && !lf_eff
                             && (held_time >= TIME_BITS'(long_press_ticks));
                        if (lp)
                        begin
                            long_fired_next = 1'b1;
                        end
                        sp = boot_release && !lf_eff;
                    end
                    // Plus steps first, then minus steps from that result.
                    if (stats[dbpl_pkg::BTN_PLUS].changed
                        && stats[dbpl_pkg::BTN_PLUS].pressed_next)
                    begin
                        mode_dn = mode_up;
                    end
                    if (stats[dbpl_pkg::BTN_MINUS].changed
                        && stats[dbpl_pkg::BTN_MINUS].pressed_next)
                    begin
                        mode_next = (mode_dn == '0) ? MODE_MAX : mode_dn - MODE_W'(1);
                    end
                    else
                    begin
                        mode_next = mode_dn;
                    end
                end
                act_out = activity_next;
            end
            dbpl_pkg::OP_SET_MODE:
            begin
                mode_next = (sample.set_value > dbpl_pkg::SET_W'(MODE_COUNT - 1))
                            ? '0 : sample.set_value[MODE_W-1:0];
            end
            dbpl_pkg::OP_ARM_IGNORE:
            begin
                ignore_next = stats[dbpl_pkg::BTN_BOOT].pressed_now;
            end
            dbpl_pkg::OP_TAKE_ACT:
            begin
                activity_next = 1'b0;
            end
            default:
            begin
                act_out = activity_reg;
            end
        endcase

        res_next.mode_value  = dbpl_pkg::MODE_OUT_W'(mode_next);
        res_next.led_boot    = lane_ctrl.step ? stats[dbpl_pkg::BTN_BOOT].pressed_next
                                              : stats[dbpl_pkg::BTN_BOOT].pressed_now;
        res_next.led_plus    = lane_ctrl.step ? stats[dbpl_pkg::BTN_PLUS].pressed_next
                                              : stats[dbpl_pkg::BTN_PLUS].pressed_now;
        res_next.led_minus   = lane_ctrl.step ? stats[dbpl_pkg::BTN_MINUS].pressed_next
                                              : stats[dbpl_pkg::BTN_MINUS].pressed_now;
        res_next.short_press = sp;
        res_next.long_press  = lp;
        res_next.activity    = act_out;

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            press_start_reg <= '0;
            long_fired_reg  <= 1'b0;
            ignore_reg      <= 1'b0;
            activity_reg    <= 1'b0;
            mode_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                started_reg     <= started_next;
                press_start_reg <= press_start_next;
                long_fired_reg  <= long_fired_next;
                ignore_reg      <= ignore_next;
                activity_reg    <= activity_next;
                mode_reg        <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.mode_value  = res_reg.mode_value;
    assign result.led_boot    = res_reg.led_boot;
    assign result.led_plus    = res_reg.led_plus;
    assign result.led_minus   = res_reg.led_minus;
    assign result.short_press = res_reg.short_press;
    assign result.long_press  = res_reg.long_press;
    assign result.activity    = res_reg.activity;

endmodule

[hw/rtl/debounced_button_panel_long_press_core.sv]
// ----------------------------------------------------------------------------
// Debounced button panel with long press
// Top level: three debounce lanes, a merge stage and the register port.
// ----------------------------------------------------------------------------
// The core takes one item per clock and returns one result per item, in the
// cycle after the transfer, through an output register. The three debounce
// lanes and the merge stage update all state at the transfer itself, so a
// new item is accepted every cycle; ready drops only while a finished
// result is held because the result channel is not ready. Register writes
// take effect on the cycle after their transfer and are accepted at any time.

`include "debounced_button_panel_long_press_core_defines.svh"

module debounced_button_panel_long_press_core #(
    parameter int MODE_COUNT = dbpl_pkg::MODE_COUNT_DEF,
    parameter int TIME_BITS  = dbpl_pkg::TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dbpl_in_if.sink    sample,
    dbpl_out_if.source result,
    dbpl_cfg_if.sink   cfg
);

    logic [dbpl_pkg::THRESH_W-1:0] debounce_reg;
    logic [dbpl_pkg::THRESH_W-1:0] long_press_reg;

    logic [TIME_BITS-1:0]                              now;
    logic [dbpl_pkg::NUM_BUTTONS-1:0]                  pressed;
    dbpl_pkg::lane_stat_t [dbpl_pkg::NUM_BUTTONS-1:0]  stats;
    dbpl_pkg::lane_ctrl_t                              lane_ctrl;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= dbpl_pkg::DEBOUNCE_RESET;
            long_press_reg <= dbpl_pkg::LONG_PRESS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == dbpl_pkg::CFG_DEBOUNCE)
            begin
                debounce_reg <= cfg.data;
            end
            else if (cfg.index == dbpl_pkg::CFG_LONG_PRESS)
            begin
                long_press_reg <= cfg.data;
            end
        end
    end

    assign now = TIME_BITS'(sample.now_tick);

    // Pins are active low.
    assign pressed[dbpl_pkg::BTN_BOOT]  = !sample.boot_level;
    assign pressed[dbpl_pkg::BTN_PLUS]  = !sample.plus_level;
    assign pressed[dbpl_pkg::BTN_MINUS] = !sample.minus_level;

    for (genvar b = 0; b < dbpl_pkg::NUM_BUTTONS; b++)
    begin : g_lane
        dbpl_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (lane_ctrl),
            .pressed       (pressed[b]),
            .now           (now),
            .debounce_ticks(debounce_reg),
            .stat          (stats[b])
        );
    end

    dbpl_merge #(
        .MODE_COUNT(MODE_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample),
        .result          (result),
        .now             (now),
        .long_press_ticks(long_press_reg),
        .stats           (stats),
        .lane_ctrl       (lane_ctrl)
    );

    // Boot cannot both fire a long press and report a short press at once.
    `DBPL_ASSERT_IMPL(a_pulse_excl, clk, rst_n, result.valid, !(result.short_press && result.long_press))
    // A long press only fires while boot is debounced as pressed.
    `DBPL_ASSERT_IMPL(a_long_held, clk, rst_n, result.valid && result.long_press, result.led_boot)
    // Every accepted item yields a result on the next cycle.
    `DBPL_ASSERT_NEXT(a_result_follows, clk, rst_n, sample.valid && sample.ready, result.valid)

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Button panel core testbench
// Drives scan samples and mode commands into the panel core, predicts every
// result from its own copy of the panel state, and compares field by field
// under several debounce and hold thresholds and handshake pressures.
// ----------------------------------------------------------------------------
module tb;

    // Pin levels are active low: bit 0 boot, bit 1 plus, bit 2 minus.
    localparam logic [2:0] PINS_UP       = 3'b111;
    localparam logic [2:0] PINS_BOOT     = 3'b110;
    localparam logic [2:0] PINS_BOOT_PLS = 3'b100;
    localparam logic [2:0] PINS_MINUS    = 3'b011;
    localparam int         PHASES        = 6;
    localparam int         PHASE_ITEMS   = 175;

    class panel_scoreboard;
        bit                  started;
        bit [2:0]            raw_down;
        bit [2:0]            held_down;
        bit [31:0]           edge_tick [dbpl_pkg::NUM_BUTTONS];
        bit [31:0]           boot_down_tick;
        bit                  long_sent;
        bit                  skip_boot;
        bit                  act_sticky;
        int                  mode_now;
        bit [15:0]           settle_ticks;
        bit [15:0]           hold_ticks;
        dbpl_pkg::res_t      due_results [$];
        int                  mismatches;

        function new();
            settle_ticks = dbpl_pkg::DEBOUNCE_RESET;
            hold_ticks   = dbpl_pkg::LONG_PRESS_RESET;
        endfunction

        function void write_reg(logic [dbpl_pkg::CFG_IDX_W-1:0] idx,
                                logic [dbpl_pkg::THRESH_W-1:0] val);
            if (idx == dbpl_pkg::CFG_DEBOUNCE)
                settle_ticks = val;
            else if (idx == dbpl_pkg::CFG_LONG_PRESS)
                hold_ticks = val;
        endfunction

        function bit ticks_passed(bit [31:0] now_t, bit [31:0] start_t, bit [15:0] lim);
            bit [31:0] span;
            span = now_t - start_t;
            return span >= {16'd0, lim};
        endfunction

        function void note_sample(dbpl_pkg::op_t op, bit [31:0] tick, bit [2:0] pins,
                                  bit [7:0] setv);
            bit [2:0]       down;
            bit [2:0]       flipped;
            dbpl_pkg::res_t want;
            down    = ~pins;
            flipped = '0;
            want    = '0;
            case (op)
                dbpl_pkg::OP_SCAN:
                begin
                    if (!started)
                    begin
                        raw_down  = down;
                        held_down = down;
                        for (int b = 0; b < dbpl_pkg::NUM_BUTTONS; b++)
                            edge_tick[b] = tick;
                        boot_down_tick = tick;
                        long_sent      = 1'b0;
                        started        = 1'b1;
                    end
                    else
                    begin
                        for (int b = 0; b < dbpl_pkg::NUM_BUTTONS; b++)
                        begin
                            if (down[b] != raw_down[b])
                            begin
                                raw_down[b]  = down[b];
                                edge_tick[b] = tick;
                            end
                            if (down[b] != held_down[b] &&
                                ticks_passed(tick, edge_tick[b], settle_ticks))
                            begin
                                held_down[b] = down[b];
                                flipped[b]   = 1'b1;
                                if (b == dbpl_pkg::BTN_BOOT && down[b])
                                begin
                                    boot_down_tick = tick;
                                    long_sent      = 1'b0;
                                end
                            end
                        end
                        if ((flipped & held_down) != 3'b000)
                            act_sticky = 1'b1;
                        if (skip_boot)
                        begin
                            // A settled release ends the ignored press.
                            if (flipped[dbpl_pkg::BTN_BOOT] && !held_down[dbpl_pkg::BTN_BOOT])
                                skip_boot = 1'b0;
                        end
                        else
                        begin
                            if (held_down[dbpl_pkg::BTN_BOOT] && !long_sent &&
                                ticks_passed(tick, boot_down_tick, hold_ticks))
                            begin
                                long_sent       = 1'b1;
                                want.long_press = 1'b1;
                            end
                            if (flipped[dbpl_pkg::BTN_BOOT] && !held_down[dbpl_pkg::BTN_BOOT]
                                && !long_sent)
                                want.short_press = 1'b1;
                        end
                        if (flipped[dbpl_pkg::BTN_PLUS] && held_down[dbpl_pkg::BTN_PLUS])
                            mode_now = (mode_now + 1) % dbpl_pkg::MODE_COUNT_DEF;
                        if (flipped[dbpl_pkg::BTN_MINUS] && held_down[dbpl_pkg::BTN_MINUS])
                            mode_now = (mode_now + dbpl_pkg::MODE_COUNT_DEF - 1)
                                       % dbpl_pkg::MODE_COUNT_DEF;
                    end
                    want.activity = act_sticky;
                end
                dbpl_pkg::OP_SET_MODE:
                begin
                    mode_now      = (setv > dbpl_pkg::MODE_COUNT_DEF - 1) ? 0 : int'(setv);
                    want.activity = act_sticky;
                end
                dbpl_pkg::OP_ARM_IGNORE:
                begin
                    skip_boot     = held_down[dbpl_pkg::BTN_BOOT];
                    want.activity = act_sticky;
                end
                default:
                begin
                    want.activity = act_sticky;
                    act_sticky    = 1'b0;
                end
            endcase
            want.mode_value = dbpl_pkg::MODE_OUT_W'(mode_now);
            want.led_boot   = held_down[dbpl_pkg::BTN_BOOT];
            want.led_plus   = held_down[dbpl_pkg::BTN_PLUS];
            want.led_minus  = held_down[dbpl_pkg::BTN_MINUS];
            due_results.push_back(want);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(dbpl_pkg::res_t got);
            dbpl_pkg::res_t want;
            if (due_results.size() == 0)
            begin
                report("result with nothing pending, mode", got.mode_value, 0);
                return;
            end
            want = due_results.pop_front();
            if (got.mode_value != want.mode_value)
                report("mode_value", got.mode_value, want.mode_value);
            if (got.led_boot != want.led_boot)
                report("led_boot", got.led_boot, want.led_boot);
            if (got.led_plus != want.led_plus)
                report("led_plus", got.led_plus, want.led_plus);
            if (got.led_minus != want.led_minus)
                report("led_minus", got.led_minus, want.led_minus);
            if (got.short_press != want.short_press)
                report("short_press", got.short_press, want.short_press);
            if (got.long_press != want.long_press)
                report("long_press", got.long_press, want.long_press);
            if (got.activity != want.activity)
                report("activity", got.activity, want.activity);
        endtask
    endclass

    logic clk;
    logic rst_n;

    dbpl_in_if  sample_if ();
    dbpl_out_if result_if ();
    dbpl_cfg_if cfg_if ();

    debounced_button_panel_long_press_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    panel_scoreboard sb = new();

    int        send_idle_pct;
    int        recv_stall_pct;
    bit [31:0] tick_now;
    bit [2:0]  pin_state;
    int        ph_settle [PHASES] = '{5, 0, 65535, 65535, 2, 30};
    int        ph_hold   [PHASES] = '{60, 65535, 65535, 0, 25, 200};
    int        ph_idle   [PHASES] = '{0, 83, 0, 33, 0, 83};
    int        ph_stall  [PHASES] = '{0, 0, 83, 33, 0, 0};

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Called at a rising edge; returns at the rising edge of the transfer.
    task push_sample(dbpl_pkg::op_t op, bit [31:0] tick, bit [2:0] pins, bit [7:0] setv);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid       <= 1'b1;
        sample_if.op          <= op;
        sample_if.now_tick    <= tick;
        sample_if.boot_level  <= pins[dbpl_pkg::BTN_BOOT];
        sample_if.plus_level  <= pins[dbpl_pkg::BTN_PLUS];
        sample_if.minus_level <= pins[dbpl_pkg::BTN_MINUS];
        sample_if.set_value   <= setv;
        forever
        begin
            @(negedge clk);
            if (sample_if.ready)
            begin
                sb.note_sample(op, tick, pins, setv);
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    // Valid stays high on return so writes can follow back to back; the
    // caller drops it after the last write.
    task write_register(logic [dbpl_pkg::CFG_IDX_W-1:0] idx,
                        logic [dbpl_pkg::THRESH_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        forever
        begin
            @(negedge clk);
            if (cfg_if.ready)
            begin
                sb.write_reg(idx, val);
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    task await_drain();
        sample_if.valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly press and release gestures on a running tick, where small steps
    // make bounces shorter than the debounce time; the rest are commands and
    // scans at random times.
    task run_random_scans(int count, int settle, int hold);
        int roll;
        int step_max;
        int step;
        step_max = (settle + hold) / 6 + 1;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                for (int b = 0; b < dbpl_pkg::NUM_BUTTONS; b++)
                    if ($urandom_range(0, 99) < 8)
                        pin_state[b] = ~pin_state[b];
                if ($urandom_range(0, 1) == 0)
                    step = $urandom_range(0, settle / 2);
                else
                    step = $urandom_range(0, step_max);
                tick_now = tick_now + step;
                push_sample(dbpl_pkg::OP_SCAN, tick_now, pin_state, 8'($urandom));
            end
            else if (roll < 80)
            begin
                push_sample(dbpl_pkg::OP_SET_MODE, $urandom, 3'($urandom),
                            ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                        : 8'($urandom_range(0, 255)));
            end
            else if (roll < 88)
                push_sample(dbpl_pkg::OP_ARM_IGNORE, $urandom, 3'($urandom), 8'($urandom));
            else if (roll < 96)
                push_sample(dbpl_pkg::OP_TAKE_ACT, $urandom, 3'($urandom), 8'($urandom));
            else
                push_sample(dbpl_pkg::OP_SCAN, $urandom, 3'($urandom), 8'($urandom));
        end
    endtask

    // The result side runs on its own; a transfer seen at the falling edge
    // completes at the next rising edge.
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            @(negedge clk);
            if (rst_n && result_if.valid && result_if.ready)
                sb.check_result('{mode_value:  result_if.mode_value,
                                  led_boot:    result_if.led_boot,
                                  led_plus:    result_if.led_plus,
                                  led_minus:   result_if.led_minus,
                                  short_press: result_if.short_press,
                                  long_press:  result_if.long_press,
                                  activity:    result_if.activity});
        end
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        bit [31:0] tk;
        rst_n                 <= 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        pin_state              = PINS_UP;
        sample_if.valid       <= 1'b0;
        sample_if.op          <= dbpl_pkg::OP_SCAN;
        sample_if.now_tick    <= '0;
        sample_if.boot_level  <= 1'b1;
        sample_if.plus_level  <= 1'b1;
        sample_if.minus_level <= 1'b1;
        sample_if.set_value   <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= dbpl_pkg::CFG_DEBOUNCE;
        cfg_if.data           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Commands before the first scan, and mode values out of range.
        push_sample(dbpl_pkg::OP_TAKE_ACT, 32'd0, PINS_UP, 8'd0);
        push_sample(dbpl_pkg::OP_ARM_IGNORE, 32'hFFFF_FFFF, 3'b000, 8'hFF);
        push_sample(dbpl_pkg::OP_SET_MODE, 32'd0, PINS_UP, 8'd3);
        push_sample(dbpl_pkg::OP_SET_MODE, 32'd0, PINS_UP, 8'd255);
        push_sample(dbpl_pkg::OP_SET_MODE, 32'd0, PINS_UP, 8'd4);
        // First scan adopts held buttons; the hold then crosses the tick wrap.
        tk = 32'hFFFF_FFF0;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT_PLS, 8'd0);
        tk += 300;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT_PLS, 8'd0);
        tk += 10;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_UP, 8'd0);
        tk += 40;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_UP, 8'd0);
        // A bouncing press, then an ignored press held past the threshold.
        tk += 5;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT, 8'd0);
        tk += 5;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_UP, 8'd0);
        tk += 5;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT, 8'd0);
        tk += 40;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT, 8'd0);
        push_sample(dbpl_pkg::OP_ARM_IGNORE, 32'd0, PINS_UP, 8'd0);
        tk += 300;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT, 8'd0);
        tk += 40;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_UP, 8'd0);
        // A short press, then a minus press that has not settled yet.
        tk += 40;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT, 8'd0);
        tk += 40;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_UP, 8'd0);
        tk += 40;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_MINUS, 8'd0);
        push_sample(dbpl_pkg::OP_TAKE_ACT, 32'd0, PINS_UP, 8'd0);
        // Zero thresholds settle and fire in the same scan.
        await_drain();
        write_register(dbpl_pkg::CFG_DEBOUNCE, 16'd0);
        write_register(dbpl_pkg::CFG_LONG_PRESS, 16'd0);
        cfg_if.valid <= 1'b0;
        tk += 1;
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_BOOT, 8'd0);
        push_sample(dbpl_pkg::OP_SCAN, tk, PINS_UP, 8'd0);
        tick_now = tk;

        for (int p = 0; p < PHASES; p++)
        begin
            await_drain();
            write_register(dbpl_pkg::CFG_DEBOUNCE, dbpl_pkg::THRESH_W'(ph_settle[p]));
            write_register(dbpl_pkg::CFG_LONG_PRESS, dbpl_pkg::THRESH_W'(ph_hold[p]));
            cfg_if.valid <= 1'b0;
            send_idle_pct  = ph_idle[p];
            recv_stall_pct = ph_stall[p];
            if (p % 2 == 1)
                tick_now = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            run_random_scans(PHASE_ITEMS, ph_settle[p], ph_hold[p]);
        end

        await_drain();
        repeat (5) @(posedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
